[rtl/acpf_pkg.sv]
package acpf_pkg;

	localparam int unsigned MAX_CHECK_DIGITS_DEF = 9;
	localparam logic [7:0] DEVICE_ID_RESET = 8'd69;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_O      = 8'h4F;
	localparam logic [7:0] CH_K      = 8'h4B;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_L      = 8'h4C;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [2:0] {
		EV_NONE,
		EV_OK,
		EV_SETUP_ERR,
		EV_LINK_CLOSED,
		EV_FRAME_OK,
		EV_CHECK_BAD,
		EV_VALUE_BAD,
		EV_OTHER_DEV
	} evt_t;

	typedef enum logic [3:0] {
		SM_IDLE,
		SM_E,
		SM_ER,
		SM_ERR,
		SM_ERRO,
		SM_O,
		SM_OK,
		SM_OKCR,
		SM_C,
		SM_CL,
		SM_CLO,
		SM_CLOS,
		SM_CLOSE,
		SM_CLOSED,
		SM_CLOSEDCR
	} sm_state_t;

	typedef enum logic [3:0] {
		FP_IDLE,
		FP_DEV,
		FP_DATA,
		FP_CHECK,
		FP_C,
		FP_CL,
		FP_CLO,
		FP_CLOS,
		FP_CLOSE,
		FP_CLOSED,
		FP_CLOSEDCR
	} fp_state_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
		logic       suppress_error_match;
	} in_item_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic       value;
		logic [7:0] frame_device;
		logic [7:0] computed_check;
		logic [7:0] received_check;
		logic       run_mode;
	} out_item_t;

	typedef struct packed {
		evt_t       ev;
		logic       value;
		logic [7:0] frame_device;
		logic [7:0] computed_check;
		logic [7:0] received_check;
	} frame_res_t;

endpackage

[rtl/at_reply_and_frame_parser.sv]
// Modem reply matcher and frame parser.
// The input channel (in_valid, in_ready, in_item) carries one received byte
// or a link-ready event per transfer. Every input transfer yields exactly one
// result transfer on the output channel (out_valid, out_ready, out_item).
// In setup mode the byte stream is matched against the OK, ERROR and CLOSED
// replies; after the link-ready event, frames of the form '#', device, data,
// decimal check, '$' are parsed until CLOSED CR LF returns to setup mode.
// The input transfer writes the input register; the parse logic then
// writes the result register, which drives out_valid.
// Throughput is one item per cycle while the receiver takes each result,
// limited only by the single result register and the state update of the
// matchers, which completes each cycle.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready then drops until the result is taken.
// Reset clears both matchers, leaves setup mode active and loads device_id
// with 69. cfg_we and cfg_wdata write the device_id register. The user must
// write it only while no item is in flight; the block does not enforce it.
module at_reply_and_frame_parser #(
	parameter int unsigned MAX_CHECK_DIGITS = acpf_pkg::MAX_CHECK_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  acpf_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output acpf_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata
);
	import acpf_pkg::*;

	in_item_t   item_s1;
	logic       valid_s1;
	out_item_t  out_item_q;
	logic       out_valid_q;
	logic       link_q;
	logic       link_n;
	logic [7:0] device_id_q;

	logic       adv;
	logic       enter;
	logic       setup_step;
	logic       frame_step;
	logic       closed;
	evt_t       setup_ev;
	frame_res_t frame_res;
	out_item_t  res;

	assign adv        = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || adv;
	assign enter      = item_s1.kind && !link_q;
	assign setup_step = adv && !item_s1.kind && !link_q;
	assign frame_step = adv && !item_s1.kind && link_q;
	assign closed     = frame_step && (frame_res.ev == EV_LINK_CLOSED);

	acpf_setup u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (setup_step),
		.clr      ((adv && enter) || closed),
		.rx_byte  (item_s1.rx_byte),
		.suppress (item_s1.suppress_error_match),
		.ev       (setup_ev)
	);

	acpf_frame #(
		.MAX_CHECK_DIGITS (MAX_CHECK_DIGITS)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (frame_step),
		.clr       (adv && enter),
		.rx_byte   (item_s1.rx_byte),
		.device_id (device_id_q),
		.res       (frame_res)
	);

	always_comb begin
		res    = '0;
		link_n = link_q;
		if (item_s1.kind) begin
			if (!link_q) begin
				link_n = 1'b1;
			end
		end else if (link_q) begin
			res.event_res      = frame_res.ev;
			res.value          = frame_res.value;
			res.frame_device   = frame_res.frame_device;
			res.computed_check = frame_res.computed_check;
			res.received_check = frame_res.received_check;
			if (frame_res.ev == EV_LINK_CLOSED) begin
				link_n = 1'b0;
			end
		end else begin
			res.event_res = setup_ev;
		end
		res.run_mode = link_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			link_q      <= 1'b0;
			device_id_q <= DEVICE_ID_RESET;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				link_q      <= link_n;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				device_id_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
		if (adv) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef ASSERT_OFF
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("processed item produced no result");

	a_run_mode_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_item_q.run_mode == link_q)
		else $error("result run mode differs from link state");

	a_setup_events: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_item_q.event_res == EV_OK ||
		out_item_q.event_res == EV_SETUP_ERR ||
		out_item_q.event_res == EV_LINK_CLOSED) |-> !out_item_q.run_mode)
		else $error("setup reply or close reported in run mode");

	a_frame_events: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_item_q.event_res == EV_FRAME_OK ||
		out_item_q.event_res == EV_CHECK_BAD ||
		out_item_q.event_res == EV_VALUE_BAD ||
		out_item_q.event_res == EV_OTHER_DEV) |-> out_item_q.run_mode)
		else $error("frame result reported in setup mode");
`endif

endmodule

[rtl/acpf_setup.sv]
module acpf_setup (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          clr,
	input  logic [7:0]    rx_byte,
	input  logic          suppress,
	output acpf_pkg::evt_t ev
);
	import acpf_pkg::*;

	sm_state_t sm_q;
	sm_state_t sm_n;

	always_comb begin
		sm_n = SM_IDLE;
		unique case (sm_q)
			SM_E:        sm_n = (rx_byte == CH_R) ? SM_ER : SM_IDLE;
			SM_ER:       sm_n = (rx_byte == CH_R) ? SM_ERR : SM_IDLE;
			SM_ERR:      sm_n = (rx_byte == CH_O) ? SM_ERRO : SM_IDLE;
			SM_ERRO:     sm_n = SM_IDLE;
			SM_O:        sm_n = (rx_byte == CH_K) ? SM_OK : SM_IDLE;
			SM_OK:       sm_n = (rx_byte == CH_CR) ? SM_OKCR : SM_IDLE;
			SM_OKCR:     sm_n = SM_IDLE;
			SM_C:        sm_n = (rx_byte == CH_L) ? SM_CL : SM_IDLE;
			SM_CL:       sm_n = (rx_byte == CH_O) ? SM_CLO : SM_IDLE;
			SM_CLO:      sm_n = (rx_byte == CH_S) ? SM_CLOS : SM_IDLE;
			SM_CLOS:     sm_n = (rx_byte == CH_E) ? SM_CLOSE : SM_IDLE;
			SM_CLOSE:    sm_n = (rx_byte == CH_D) ? SM_CLOSED : SM_IDLE;
			SM_CLOSED:   sm_n = (rx_byte == CH_CR) ? SM_CLOSEDCR : SM_IDLE;
			SM_CLOSEDCR: sm_n = (rx_byte == CH_LF) ? SM_IDLE : SM_CLOSEDCR;
			default: begin
				priority if (rx_byte == CH_C) begin
					sm_n = SM_C;
				end else if (rx_byte == CH_E && !suppress) begin
					sm_n = SM_E;
				end else if (rx_byte == CH_O) begin
					sm_n = SM_O;
				end else begin
					sm_n = SM_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		ev = EV_NONE;
		unique case (sm_q)
			SM_ERRO:     ev = (rx_byte == CH_R) ? EV_SETUP_ERR : EV_NONE;
			SM_OKCR:     ev = (rx_byte == CH_LF) ? EV_OK : EV_NONE;
			SM_CLOSEDCR: ev = (rx_byte == CH_LF) ? EV_SETUP_ERR : EV_NONE;
			default:     ev = EV_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sm_q <= SM_IDLE;
		end else if (clr) begin
			sm_q <= SM_IDLE;
		end else if (step) begin
			sm_q <= sm_n;
		end
	end

endmodule

[rtl/acpf_frame.sv]
module acpf_frame #(
	parameter int unsigned MAX_CHECK_DIGITS = acpf_pkg::MAX_CHECK_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                clr,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          device_id,
	output acpf_pkg::frame_res_t res
);
	import acpf_pkg::*;

	localparam int unsigned DCW = $clog2(MAX_CHECK_DIGITS + 1);

	fp_state_t      fp_q;
	fp_state_t      fp_n;
	logic [7:0]     dev_q;
	logic [7:0]     data_q;
	logic [7:0]     xor_q;
	logic [7:0]     dec_q;
	logic [DCW-1:0] dc_q;
	logic           stop_q;

	logic [7:0]     dev_n;
	logic [7:0]     data_n;
	logic [7:0]     xor_n;
	logic [7:0]     dec_n;
	logic [DCW-1:0] dc_n;
	logic           stop_n;

	logic           is_digit;
	logic           is_space;
	logic [7:0]     val;

	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign is_space = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
	assign val      = data_q - CH_ZERO;

	always_comb begin
		fp_n = FP_IDLE;
		unique case (fp_q)
			FP_DEV:      fp_n = FP_DATA;
			FP_DATA:     fp_n = FP_CHECK;
			FP_CHECK:    fp_n = (rx_byte == CH_DOLLAR) ? FP_IDLE : FP_CHECK;
			FP_C:        fp_n = (rx_byte == CH_L) ? FP_CL : FP_IDLE;
			FP_CL:       fp_n = (rx_byte == CH_O) ? FP_CLO : FP_IDLE;
			FP_CLO:      fp_n = (rx_byte == CH_S) ? FP_CLOS : FP_IDLE;
			FP_CLOS:     fp_n = (rx_byte == CH_E) ? FP_CLOSE : FP_IDLE;
			FP_CLOSE:    fp_n = (rx_byte == CH_D) ? FP_CLOSED : FP_IDLE;
			FP_CLOSED:   fp_n = (rx_byte == CH_CR) ? FP_CLOSEDCR : FP_IDLE;
			FP_CLOSEDCR: fp_n = FP_IDLE;
			default: begin
				priority if (rx_byte == CH_HASH) begin
					fp_n = FP_DEV;
				end else if (rx_byte == CH_C) begin
					fp_n = FP_C;
				end else begin
					fp_n = FP_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		dev_n  = dev_q;
		data_n = data_q;
		xor_n  = xor_q;
		dec_n  = dec_q;
		dc_n   = dc_q;
		stop_n = stop_q;
		unique case (fp_q)
			FP_DEV: begin
				dev_n  = rx_byte;
				xor_n  = rx_byte;
				dec_n  = '0;
				dc_n   = '0;
				stop_n = 1'b0;
			end
			FP_DATA: begin
				data_n = rx_byte;
				xor_n  = xor_q ^ rx_byte;
			end
			FP_CHECK: begin
				if (rx_byte == CH_DOLLAR) begin
					dec_n  = '0;
					dc_n   = '0;
					stop_n = 1'b0;
				end else if (!stop_q) begin
					if (is_digit) begin
						if (dc_q < DCW'(MAX_CHECK_DIGITS)) begin
							dec_n = (dec_q << 3) + (dec_q << 1) + (rx_byte - CH_ZERO);
							dc_n  = dc_q + 1'b1;
						end else begin
							stop_n = 1'b1;
						end
					end else if (!(dc_q == '0 && is_space)) begin
						stop_n = 1'b1;
					end
				end
			end
			default: begin
				dev_n = dev_q;
			end
		endcase
	end

	always_comb begin
		res = '{ev: EV_NONE, value: 1'b0, frame_device: 8'd0,
			computed_check: 8'd0, received_check: 8'd0};
		unique case (fp_q)
			FP_CHECK: begin
				if (rx_byte == CH_DOLLAR) begin
					res.frame_device   = dev_q;
					res.computed_check = xor_q;
					res.received_check = dec_q;
					priority if (dev_q != device_id) begin
						res.ev = EV_OTHER_DEV;
					end else if (xor_q != dec_q) begin
						res.ev = EV_CHECK_BAD;
					end else if (val[7:1] != 7'd0) begin
						res.ev = EV_VALUE_BAD;
					end else begin
						res.ev    = EV_FRAME_OK;
						res.value = val[0];
					end
				end
			end
			FP_CLOSEDCR: begin
				res.ev = (rx_byte == CH_LF) ? EV_LINK_CLOSED : EV_NONE;
			end
			default: begin
				res.ev = EV_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q   <= FP_IDLE;
			dev_q  <= '0;
			data_q <= '0;
			xor_q  <= '0;
			dec_q  <= '0;
			dc_q   <= '0;
			stop_q <= 1'b0;
		end else if (clr) begin
			fp_q <= FP_IDLE;
		end else if (step) begin
			fp_q   <= fp_n;
			dev_q  <= dev_n;
			data_q <= data_n;
			xor_q  <= xor_n;
			dec_q  <= dec_n;
			dc_q   <= dc_n;
			stop_q <= stop_n;
		end
	end

endmodule

[tb/sv/tb_top.sv]
module tb_top;
	import acpf_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;
	logic      cfg_we;
	logic [7:0] cfg_wdata;

	at_reply_and_frame_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Parser state as this bench expects it.
	logic [7:0] dev_id;
	sm_state_t  sm_pos;
	fp_state_t  fp_pos;
	logic       lnk_up;
	logic [7:0] dev_b;
	logic [7:0] data_b;
	logic [7:0] xor_v;
	logic [7:0] chk_val;
	logic [3:0] chk_digits;
	logic       chk_stopped;

	out_item_t   due_results[$];
	logic [7:0]  byte_q[$];
	int          mismatches = 0;
	int unsigned cycle_cnt = 0;
	int          burst_left = 0;
	int unsigned traffic_count;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic out_item_t next_parser_result(input in_item_t it);
		out_item_t  r;
		logic [7:0] b;
		logic [7:0] val;
		evt_t       ev;
		r = '0;
		ev = EV_NONE;
		b = it.rx_byte;
		if (it.kind) begin
			if (!lnk_up) begin
				lnk_up = 1'b1;
				sm_pos = SM_IDLE;
				fp_pos = FP_IDLE;
			end
		end else if (!lnk_up) begin
			case (sm_pos)
				SM_E: sm_pos = (b == CH_R) ? SM_ER : SM_IDLE;
				SM_ER: sm_pos = (b == CH_R) ? SM_ERR : SM_IDLE;
				SM_ERR: sm_pos = (b == CH_O) ? SM_ERRO : SM_IDLE;
				SM_ERRO: begin
					if (b == CH_R)
						ev = EV_SETUP_ERR;
					sm_pos = SM_IDLE;
				end
				SM_O: sm_pos = (b == CH_K) ? SM_OK : SM_IDLE;
				SM_OK: sm_pos = (b == CH_CR) ? SM_OKCR : SM_IDLE;
				SM_OKCR: begin
					if (b == CH_LF)
						ev = EV_OK;
					sm_pos = SM_IDLE;
				end
				SM_C: sm_pos = (b == CH_L) ? SM_CL : SM_IDLE;
				SM_CL: sm_pos = (b == CH_O) ? SM_CLO : SM_IDLE;
				SM_CLO: sm_pos = (b == CH_S) ? SM_CLOS : SM_IDLE;
				SM_CLOS: sm_pos = (b == CH_E) ? SM_CLOSE : SM_IDLE;
				SM_CLOSE: sm_pos = (b == CH_D) ? SM_CLOSED : SM_IDLE;
				SM_CLOSED: sm_pos = (b == CH_CR) ? SM_CLOSEDCR : SM_IDLE;
				SM_CLOSEDCR: begin
					// After CLOSED CR, every byte but LF is ignored.
					if (b == CH_LF) begin
						ev = EV_SETUP_ERR;
						sm_pos = SM_IDLE;
					end
				end
				default: begin
					sm_pos = SM_IDLE;
					if (b == CH_O)
						sm_pos = SM_O;
					if (b == CH_E && !it.suppress_error_match)
						sm_pos = SM_E;
					if (b == CH_C)
						sm_pos = SM_C;
				end
			endcase
		end else begin
			case (fp_pos)
				FP_DEV: begin
					dev_b = b;
					xor_v = b;
					chk_val = '0;
					chk_digits = '0;
					chk_stopped = 1'b0;
					fp_pos = FP_DATA;
				end
				FP_DATA: begin
					data_b = b;
					xor_v = xor_v ^ b;
					fp_pos = FP_CHECK;
				end
				FP_CHECK: begin
					if (b != CH_DOLLAR) begin
						if (!chk_stopped) begin
							if (b >= CH_ZERO && b <= CH_NINE) begin
								if (chk_digits < MAX_CHECK_DIGITS_DEF) begin
									chk_val = chk_val * 8'd10 + (b - CH_ZERO);
									chk_digits = chk_digits + 4'd1;
								end else begin
									chk_stopped = 1'b1;
								end
							end else if (!(chk_digits == 0 &&
									(b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)))) begin
								chk_stopped = 1'b1;
							end
						end
					end else begin
						val = data_b - CH_ZERO;
						r.frame_device = dev_b;
						r.computed_check = xor_v;
						r.received_check = chk_val;
						if (dev_b != dev_id)
							ev = EV_OTHER_DEV;
						else if (xor_v != chk_val)
							ev = EV_CHECK_BAD;
						else if (val > 8'd1)
							ev = EV_VALUE_BAD;
						else begin
							ev = EV_FRAME_OK;
							r.value = val[0];
						end
						chk_val = '0;
						chk_digits = '0;
						chk_stopped = 1'b0;
						fp_pos = FP_IDLE;
					end
				end
				FP_C: fp_pos = (b == CH_L) ? FP_CL : FP_IDLE;
				FP_CL: fp_pos = (b == CH_O) ? FP_CLO : FP_IDLE;
				FP_CLO: fp_pos = (b == CH_S) ? FP_CLOS : FP_IDLE;
				FP_CLOS: fp_pos = (b == CH_E) ? FP_CLOSE : FP_IDLE;
				FP_CLOSE: fp_pos = (b == CH_D) ? FP_CLOSED : FP_IDLE;
				FP_CLOSED: fp_pos = (b == CH_CR) ? FP_CLOSEDCR : FP_IDLE;
				FP_CLOSEDCR: begin
					if (b == CH_LF) begin
						lnk_up = 1'b0;
						sm_pos = SM_IDLE;
						ev = EV_LINK_CLOSED;
					end
					fp_pos = FP_IDLE;
				end
				default: begin
					fp_pos = FP_IDLE;
					if (b == CH_C)
						fp_pos = FP_C;
					if (b == CH_HASH)
						fp_pos = FP_DEV;
				end
			endcase
		end
		r.event_res = ev;
		r.run_mode = lnk_up;
		return r;
	endfunction

	// The sender works in bursts; valid stays high across a burst.
	task automatic send_item(input in_item_t it);
		int gap;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		due_results.push_back(next_parser_result(it));
		burst_left--;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic sup);
		in_item_t it;
		it.kind = 1'b0;
		it.rx_byte = b;
		it.suppress_error_match = sup;
		send_item(it);
	endtask

	task automatic send_bytes(input bit rand_sup);
		while (byte_q.size() != 0)
			send_byte(byte_q.pop_front(), rand_sup && ($urandom_range(0, 3) == 0));
	endtask

	task automatic send_link_event();
		in_item_t it;
		it.kind = 1'b1;
		it.rx_byte = 8'($urandom);
		it.suppress_error_match = 1'($urandom);
		send_item(it);
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			byte_q.push_back(s[i]);
	endtask

	task automatic push_decimal(input int unsigned n, input int zeros);
		logic [7:0] digs[$];
		repeat (zeros) byte_q.push_back(CH_ZERO);
		do begin
			digs.push_front(CH_ZERO + 8'(n % 10));
			n = n / 10;
		end while (n != 0);
		foreach (digs[i])
			byte_q.push_back(digs[i]);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_device_id(input logic [7:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		dev_id = v;
	endtask

	// Queues one frame with random content; some are malformed on purpose.
	task automatic gen_frame();
		logic [7:0]  dv;
		logic [7:0]  dt;
		int unsigned chk;
		int          zeros;
		int          sel;
		dv = ($urandom_range(0, 5) == 0) ? 8'($urandom) : dev_id;
		dt = ($urandom_range(0, 4) == 0) ? 8'($urandom) : CH_ZERO + 8'($urandom_range(0, 1));
		byte_q.push_back(CH_HASH);
		byte_q.push_back(dv);
		byte_q.push_back(dt);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				byte_q.push_back($urandom_range(0, 1) ? CH_SPACE :
					CH_TAB + 8'($urandom_range(0, 4)));
		chk = dv ^ dt;
		zeros = 0;
		sel = $urandom_range(0, 11);
		case (sel)
			0: chk = $urandom_range(0, 999);
			1: chk = chk + 256 * $urandom_range(1, 3);
			2: zeros = $urandom_range(1, 8);
			default: ;
		endcase
		if (sel != 3)
			push_decimal(chk, zeros);
		if ($urandom_range(0, 5) == 0) begin
			byte_q.push_back($urandom_range(0, 1) ? CH_MINUS : 8'($urandom));
			push_decimal($urandom_range(0, 9), 0);
		end
		if ($urandom_range(0, 15) != 0)
			byte_q.push_back(CH_DOLLAR);
	endtask

	task automatic test_setup_replies();
		push_str("OK\r\nERROR");
		send_bytes(1'b0);
		send_byte(CH_E, 1'b1);
		send_byte(CH_R, 1'b0);
		push_str("CLOSED\r");
		send_bytes(1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(CH_LF, 1'b0);
	endtask

	task automatic test_link_and_frame();
		send_link_event();
		send_link_event();
		push_str("#E1 116$");
		send_bytes(1'b0);
	endtask

	task automatic test_random_traffic(input int unsigned n_items);
		traffic_count = 0;
		while (traffic_count < n_items) begin
			if (!lnk_up) begin
				case ($urandom_range(0, 9))
					0, 1: push_str("OK\r\n");
					2, 3: push_str("ERROR");
					4: begin
						push_str("CLOSED\r");
						repeat ($urandom_range(0, 2)) byte_q.push_back(8'($urandom));
						byte_q.push_back(CH_LF);
					end
					5: begin
						repeat ($urandom_range(1, 3)) byte_q.push_back(8'($urandom));
						send_bytes(1'b1);
					end
					default: begin
						send_link_event();
						traffic_count++;
					end
				endcase
			end else begin
				case ($urandom_range(0, 11))
					0: push_str("CLOSED\r\n");
					1: begin
						repeat ($urandom_range(1, 3)) byte_q.push_back(8'($urandom));
						send_bytes(1'b1);
					end
					2: send_link_event();
					default: gen_frame();
				endcase
			end
			if (byte_q.size() != 0 && $urandom_range(0, 9) == 0)
				byte_q[$urandom_range(0, byte_q.size() - 1)] = 8'($urandom);
			traffic_count += byte_q.size();
			send_bytes(1'b1);
		end
	endtask

	// The receiver switches between stall rates on its own schedule.
	initial begin : result_stalls
		int pct;
		int left;
		pct = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				case ($urandom_range(0, 3))
					0: pct = 0;
					1: pct = 25;
					2: pct = 60;
					default: pct = 90;
				endcase
				left = $urandom_range(16, 96);
			end
			left--;
			out_ready <= ($urandom_range(0, 99) >= pct);
		end
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[at_reply_and_frame_parser] ERROR");
			$finish;
		end else if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				$error("result transfer with no expected result");
				mismatches++;
			end else begin
				want = due_results.pop_front();
				if (out_item.event_res !== want.event_res) begin
					$error("event_res: expected %0d, actual %0d",
						want.event_res, out_item.event_res);
					mismatches++;
				end
				if (out_item.value !== want.value) begin
					$error("value: expected %0d, actual %0d", want.value, out_item.value);
					mismatches++;
				end
				if (out_item.frame_device !== want.frame_device) begin
					$error("frame_device: expected %0d, actual %0d",
						want.frame_device, out_item.frame_device);
					mismatches++;
				end
				if (out_item.computed_check !== want.computed_check) begin
					$error("computed_check: expected %0d, actual %0d",
						want.computed_check, out_item.computed_check);
					mismatches++;
				end
				if (out_item.received_check !== want.received_check) begin
					$error("received_check: expected %0d, actual %0d",
						want.received_check, out_item.received_check);
					mismatches++;
				end
				if (out_item.run_mode !== want.run_mode) begin
					$error("run_mode: expected %0d, actual %0d",
						want.run_mode, out_item.run_mode);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		dev_id = DEVICE_ID_RESET;
		sm_pos = SM_IDLE;
		fp_pos = FP_IDLE;
		lnk_up = 1'b0;
		dev_b = '0;
		data_b = '0;
		xor_v = '0;
		chk_val = '0;
		chk_digits = '0;
		chk_stopped = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_setup_replies();
		test_link_and_frame();
		write_device_id(8'd255);
		test_random_traffic(150);
		write_device_id(8'd0);
		test_random_traffic(150);
		write_device_id(8'($urandom));
		test_random_traffic(150);
		write_device_id(8'($urandom));
		test_random_traffic(150);
		write_device_id(DEVICE_ID_RESET);
		test_random_traffic(150);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[at_reply_and_frame_parser] OK");
		else
			$display("[at_reply_and_frame_parser] ERROR");
		$finish;
	end

endmodule
